// File: sv/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// plain property checked on every rising clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// implication checked on every rising clock edge outside reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`endif

// File: sv/cmc_pkg.sv
// ----------------------------------------------------------------------------
// cmc_pkg
// types and codes of the closable message channel
// ----------------------------------------------------------------------------
package cmc_pkg;

    // item actions
    localparam logic [1:0] ACT_SEND     = 2'd0;
    localparam logic [1:0] ACT_RECV     = 2'd1;
    localparam logic [1:0] ACT_CLOSE    = 2'd2;
    localparam logic [1:0] ACT_ANNOUNCE = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BLOCK = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;
    localparam logic [1:0] ST_EOS   = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_CAPACITY   = 2'd0;
    localparam logic [1:0] CFG_RENDEZVOUS = 2'd1;

    localparam logic [7:0] DEMAND_MAX = 8'd255;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DRAIN
    } t_state;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] payload;
        logic        payload_is_eof;
        logic [7:0]  waiter_id;
        logic        waiter_valid;
        logic        holds_demand;
    } t_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] data;
        logic [7:0]  notify_id;
        logic        notify_valid;
        logic        is_closed;
        logic        last;
    } t_result;

endpackage

// File: sv/closable_message_channel_top.sv
// ----------------------------------------------------------------------------
// closable_message_channel_top
// bounded message channel with close, rendezvous and waiter lists
// ----------------------------------------------------------------------------
// An item is taken when i_start is high and o_busy low. Its results follow
// one per cycle on o_result, each marked by o_strobe for one cycle; the
// receiver cannot stall them, the last one carries last. The status result
// appears in the cycle after acceptance. o_busy is high while the status
// result and each notification go out, and while a blocked caller's id is
// checked against a non-empty waiter list, so no new item is taken before the
// last one is through. The message store and the two waiter lists are
// memories with a registered read, walked one entry a cycle.
module closable_message_channel_top #(
    parameter int STORE_DEPTH  = 16,
    parameter int WAITER_SLOTS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  cmc_pkg::t_item   i_item,
    output logic             o_busy,
    output logic             o_strobe,
    output cmc_pkg::t_result o_result,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [1:0]       i_cfg_index,
    input  logic [4:0]       i_cfg_data
);

    localparam int PW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam int BW = (CW > 8) ? CW : 8;
    localparam int IW = (WAITER_SLOTS > 1) ? $clog2(WAITER_SLOTS) : 1;
    localparam int TW = $clog2(WAITER_SLOTS + 1);
    localparam logic [BW-1:0] DEPTH_B = BW'(STORE_DEPTH);
    localparam logic [PW-1:0] PTR_LAST = PW'(STORE_DEPTH - 1);
    localparam logic [TW-1:0] SLOTS_T = TW'(WAITER_SLOTS);

    // memories
    logic [63:0] r_store [STORE_DEPTH];
    logic [7:0]  r_slist [WAITER_SLOTS];
    logic [7:0]  r_rlist [WAITER_SLOTS];
    logic [63:0] r_store_q;
    logic [7:0]  r_slist_q, r_rlist_q;

    // control state
    cmc_pkg::t_state r_state, n_state;
    cmc_pkg::t_item  r_item;
    logic [PW-1:0]   r_rp, n_rp, r_wp, n_wp;
    logic [CW-1:0]   r_total, n_total;
    logic            r_closed, n_closed;
    logic [7:0]      r_demand, n_demand;
    logic [TW-1:0]   r_stot, n_stot, r_rtot, n_rtot;
    logic [IW-1:0]   r_idx, n_idx;
    logic            r_sel, n_sel;
    logic [4:0]      r_cap;
    logic            r_rdv;

    // write ports
    logic            store_we, slist_we, rlist_we;
    logic [IW-1:0]   list_wa;

    // helper values
    logic [BW-1:0]   bound;
    logic            send_ok;
    logic [TW-1:0]   sel_tot;
    logic [7:0]      sel_q;
    logic            holds_rel;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = (r_state != cmc_pkg::S_IDLE);

    // send bound
    always_comb begin
        if (r_cap == 5'd0) begin
            bound = r_rdv ? BW'(r_demand) : DEPTH_B;
        end else begin
            bound = BW'(r_cap);
        end
        if (bound > DEPTH_B) begin
            bound = DEPTH_B;
        end
        send_ok = !r_closed && (BW'(r_total) < bound);
    end

    assign sel_tot   = r_sel ? r_rtot : r_stot;
    assign sel_q     = r_sel ? r_rlist_q : r_slist_q;
    assign holds_rel = r_item.holds_demand && (r_demand != 8'd0);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= 5'd0;
            r_rdv <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                cmc_pkg::CFG_CAPACITY:   r_cap <= i_cfg_data;
                cmc_pkg::CFG_RENDEZVOUS: r_rdv <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // next state and results
    always_comb begin
        n_state  = r_state;
        n_rp     = r_rp;
        n_wp     = r_wp;
        n_total  = r_total;
        n_closed = r_closed;
        n_demand = r_demand;
        n_stot   = r_stot;
        n_rtot   = r_rtot;
        n_idx    = r_idx;
        n_sel    = r_sel;
        store_we = 1'b0;
        slist_we = 1'b0;
        rlist_we = 1'b0;
        list_wa  = sel_tot[IW-1:0];
        o_strobe = 1'b0;
        o_result = '0;
        case (r_state)
            cmc_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state = cmc_pkg::S_EXEC;
                end
            end
            cmc_pkg::S_EXEC: begin
                o_strobe         = 1'b1;
                o_result.status  = cmc_pkg::ST_OK;
                o_result.last    = 1'b1;
                n_state          = cmc_pkg::S_IDLE;
                n_idx            = '0;
                case (r_item.action)
                    cmc_pkg::ACT_SEND: begin
                        n_sel = 1'b0;
                        if (r_item.payload_is_eof || r_closed) begin
                            o_result.status = cmc_pkg::ST_ERROR;
                        end else if (!send_ok) begin
                            o_result.status = cmc_pkg::ST_BLOCK;
                            if (r_item.waiter_valid) begin
                                if (r_stot != '0) begin
                                    n_state = cmc_pkg::S_SCAN;
                                end else begin
                                    slist_we = 1'b1;
                                    list_wa  = '0;
                                    n_stot   = TW'(1);
                                end
                            end
                        end else begin
                            store_we = 1'b1;
                            n_wp     = (r_wp == PTR_LAST) ? '0 : r_wp + PW'(1);
                            n_total  = r_total + CW'(1);
                            if (r_rdv && r_cap == 5'd0 && r_demand != 8'd0) begin
                                n_demand = r_demand - 8'd1;
                            end
                            if (r_rtot != '0) begin
                                o_result.last = 1'b0;
                                n_sel         = 1'b1;
                                n_state       = cmc_pkg::S_DRAIN;
                            end
                        end
                    end
                    cmc_pkg::ACT_RECV: begin
                        n_sel = 1'b1;
                        if (r_total == '0) begin
                            if (r_closed) begin
                                o_result.status = cmc_pkg::ST_EOS;
                                if (holds_rel) begin
                                    n_demand = r_demand - 8'd1;
                                end
                            end else begin
                                o_result.status = cmc_pkg::ST_BLOCK;
                                if (r_item.waiter_valid) begin
                                    if (r_rtot != '0) begin
                                        n_state = cmc_pkg::S_SCAN;
                                    end else begin
                                        rlist_we = 1'b1;
                                        list_wa  = '0;
                                        n_rtot   = TW'(1);
                                    end
                                end
                            end
                        end else begin
                            o_result.data = r_store_q;
                            n_rp    = (r_rp == PTR_LAST) ? '0 : r_rp + PW'(1);
                            n_total = r_total - CW'(1);
                            if (holds_rel) begin
                                n_demand = r_demand - 8'd1;
                            end
                            if (r_stot != '0) begin
                                o_result.last = 1'b0;
                                n_sel         = 1'b0;
                                n_state       = cmc_pkg::S_DRAIN;
                            end
                        end
                    end
                    cmc_pkg::ACT_CLOSE: begin
                        n_closed = 1'b1;
                        if (r_stot != '0) begin
                            o_result.last = 1'b0;
                            n_sel         = 1'b0;
                            n_state       = cmc_pkg::S_DRAIN;
                        end else if (r_rtot != '0) begin
                            o_result.last = 1'b0;
                            n_sel         = 1'b1;
                            n_state       = cmc_pkg::S_DRAIN;
                        end
                    end
                    default: begin
                        if (r_rdv && r_cap == 5'd0 && !r_closed &&
                            r_demand != cmc_pkg::DEMAND_MAX) begin
                            n_demand = r_demand + 8'd1;
                        end
                    end
                endcase
                o_result.is_closed = n_closed;
            end
            cmc_pkg::S_SCAN: begin
                // compare one listed id a cycle, append at the end if absent and not full
                if (sel_q == r_item.waiter_id) begin
                    n_state = cmc_pkg::S_IDLE;
                end else if (TW'(r_idx) == sel_tot - TW'(1)) begin
                    n_state = cmc_pkg::S_IDLE;
                    if (sel_tot < SLOTS_T) begin
                        if (r_sel) begin
                            rlist_we = 1'b1;
                            n_rtot   = r_rtot + TW'(1);
                        end else begin
                            slist_we = 1'b1;
                            n_stot   = r_stot + TW'(1);
                        end
                    end
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            cmc_pkg::S_DRAIN: begin
                // one notification a cycle
                o_strobe              = 1'b1;
                o_result.status       = cmc_pkg::ST_OK;
                o_result.notify_id    = sel_q;
                o_result.notify_valid = 1'b1;
                o_result.is_closed    = r_closed;
                if (TW'(r_idx) == sel_tot - TW'(1)) begin
                    n_idx = '0;
                    if (r_sel) begin
                        n_rtot = '0;
                    end else begin
                        n_stot = '0;
                    end
                    if (!r_sel && r_item.action == cmc_pkg::ACT_CLOSE &&
                        r_rtot != '0) begin
                        n_sel = 1'b1;
                    end else begin
                        o_result.last = 1'b1;
                        n_state       = cmc_pkg::S_IDLE;
                    end
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            default: begin
                n_state = cmc_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= cmc_pkg::S_IDLE;
            r_rp     <= '0;
            r_wp     <= '0;
            r_total  <= '0;
            r_closed <= 1'b0;
            r_demand <= 8'd0;
            r_stot   <= '0;
            r_rtot   <= '0;
            r_idx    <= '0;
            r_sel    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rp     <= n_rp;
            r_wp     <= n_wp;
            r_total  <= n_total;
            r_closed <= n_closed;
            r_demand <= n_demand;
            r_stot   <= n_stot;
            r_rtot   <= n_rtot;
            r_idx    <= n_idx;
            r_sel    <= n_sel;
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (r_state == cmc_pkg::S_IDLE && i_start) begin
            r_item <= i_item;
        end
    end

    // message store
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[r_wp] <= r_item.payload;
        end
        r_store_q <= r_store[r_rp];
    end

    // waiter lists
    always_ff @(posedge i_clk) begin
        if (slist_we) begin
            r_slist[list_wa] <= r_item.waiter_id;
        end
        if (rlist_we) begin
            r_rlist[list_wa] <= r_item.waiter_id;
        end
        r_slist_q <= r_slist[n_idx];
        r_rlist_q <= r_rlist[n_idx];
    end

    // checks
    `include "assert_macros.svh"

    `ASSERT_IMPLY(a_strobe_busy, i_clk, i_rst_n, o_strobe, r_state != cmc_pkg::S_IDLE)
    `ASSERT_ALWAYS(a_total_range, i_clk, i_rst_n, r_total <= CW'(STORE_DEPTH))
    `ASSERT_ALWAYS(a_lists_range, i_clk, i_rst_n, (r_stot <= SLOTS_T) && (r_rtot <= SLOTS_T))

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// checks the closable message channel against a behavioural predictor
// ----------------------------------------------------------------------------
// Each item accepted by the block is run through a predictor of the channel,
// which queues the status result and any wake-up results it should cause. A
// monitor compares every strobed result with the oldest queued one. The
// configuration registers are rewritten only while the block is idle, and
// the run passes through several capacity and rendezvous settings.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 16;
    localparam int SLOTS = 8;

    logic             clk;
    logic             rst_n;
    logic             start;
    cmc_pkg::t_item   item_in;
    logic             busy;
    logic             strobe;
    cmc_pkg::t_result res_out;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [1:0]       cfg_index;
    logic [4:0]       cfg_data;

    closable_message_channel_top dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .i_item(item_in),
        .o_busy(busy), .o_strobe(strobe), .o_result(res_out),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    // clock
    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // predicted channel state
    logic [63:0] msg_fifo[$];
    logic [7:0]  blocked_tx_ids[$];
    logic [7:0]  blocked_rx_ids[$];
    logic        chan_closed;
    int          demand;
    int          cap_reg;
    logic        rdv_reg;

    cmc_pkg::t_item   pending_items[$];
    cmc_pkg::t_result expected_results[$];
    int      fail_count;
    bit      quiet;
    bit      cfg_busy;

    function automatic cmc_pkg::t_result make_result(logic [1:0] st, logic [63:0] d,
                                                     logic [7:0] id, logic nv);
        cmc_pkg::t_result r;
        r.status       = st;
        r.data         = d;
        r.notify_id    = id;
        r.notify_valid = nv;
        r.is_closed    = chan_closed;
        r.last         = 1'b0;
        return r;
    endfunction

    function automatic void enlist_waiter(ref logic [7:0] lst[$], input cmc_pkg::t_item it);
        if (!it.waiter_valid) return;
        foreach (lst[i]) if (lst[i] == it.waiter_id) return;
        if (lst.size() >= SLOTS) return;
        lst.push_back(it.waiter_id);
    endfunction

    function automatic void wake_all(ref logic [7:0] lst[$]);
        foreach (lst[i])
            expected_results.push_back(make_result(cmc_pkg::ST_OK, 64'd0, lst[i], 1'b1));
        lst.delete();
    endfunction

    // works out the results of one accepted item
    function automatic void predict_channel(cmc_pkg::t_item it);
        int bound;
        if (it.action == cmc_pkg::ACT_SEND) begin
            if (cap_reg == 0 && !rdv_reg) bound = DEPTH;
            else if (cap_reg == 0) bound = demand;
            else bound = cap_reg;
            if (bound > DEPTH) bound = DEPTH;
            if (it.payload_is_eof || chan_closed) begin
                expected_results.push_back(
                    make_result(cmc_pkg::ST_ERROR, 64'd0, 8'd0, 1'b0));
            end else if (msg_fifo.size() >= bound) begin
                enlist_waiter(blocked_tx_ids, it);
                expected_results.push_back(
                    make_result(cmc_pkg::ST_BLOCK, 64'd0, 8'd0, 1'b0));
            end else begin
                msg_fifo.push_back(it.payload);
                if (rdv_reg && cap_reg == 0 && demand > 0) demand--;
                expected_results.push_back(make_result(cmc_pkg::ST_OK, 64'd0, 8'd0, 1'b0));
                wake_all(blocked_rx_ids);
            end
        end else if (it.action == cmc_pkg::ACT_RECV) begin
            if (msg_fifo.size() == 0) begin
                if (chan_closed) begin
                    if (it.holds_demand && demand > 0) demand--;
                    expected_results.push_back(
                        make_result(cmc_pkg::ST_EOS, 64'd0, 8'd0, 1'b0));
                end else begin
                    enlist_waiter(blocked_rx_ids, it);
                    expected_results.push_back(
                        make_result(cmc_pkg::ST_BLOCK, 64'd0, 8'd0, 1'b0));
                end
            end else begin
                if (it.holds_demand && demand > 0) demand--;
                expected_results.push_back(
                    make_result(cmc_pkg::ST_OK, msg_fifo.pop_front(), 8'd0, 1'b0));
                wake_all(blocked_tx_ids);
            end
        end else if (it.action == cmc_pkg::ACT_CLOSE) begin
            chan_closed = 1'b1;
            expected_results.push_back(make_result(cmc_pkg::ST_OK, 64'd0, 8'd0, 1'b0));
            wake_all(blocked_tx_ids);
            wake_all(blocked_rx_ids);
        end else begin
            if (rdv_reg && cap_reg == 0 && !chan_closed && demand < 255) demand++;
            expected_results.push_back(make_result(cmc_pkg::ST_OK, 64'd0, 8'd0, 1'b0));
        end
        expected_results[$].last = 1'b1;
    endfunction

    // driver: feeds items from the pending queue, with random gaps unless quiet
    always @(posedge clk) begin
        if (!rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                predict_channel(item_in);
                void'(pending_items.pop_front());
            end
            if ((start && !busy) || !start) begin
                if (pending_items.size() > 0 && (quiet || $urandom_range(99) >= 14)) begin
                    start   <= 1'b1;
                    item_in <= pending_items[0];
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: compares each strobed result with the oldest expectation
    always @(posedge clk) begin
        cmc_pkg::t_result e;
        if (rst_n && strobe) begin
            if (expected_results.size() == 0) begin
                $error("result with none expected: %h", res_out);
                fail_count++;
            end else begin
                e = expected_results.pop_front();
                if (res_out.status !== e.status) begin
                    $error("status expected %0d got %0d", e.status, res_out.status);
                    fail_count++;
                end
                if (res_out.data !== e.data) begin
                    $error("data expected %h got %h", e.data, res_out.data);
                    fail_count++;
                end
                if (res_out.notify_id !== e.notify_id) begin
                    $error("notify_id expected %0d got %0d", e.notify_id,
                           res_out.notify_id);
                    fail_count++;
                end
                if (res_out.notify_valid !== e.notify_valid) begin
                    $error("notify_valid expected %0b got %0b", e.notify_valid,
                           res_out.notify_valid);
                    fail_count++;
                end
                if (res_out.is_closed !== e.is_closed) begin
                    $error("is_closed expected %0b got %0b", e.is_closed,
                           res_out.is_closed);
                    fail_count++;
                end
                if (res_out.last !== e.last) begin
                    $error("last expected %0b got %0b", e.last, res_out.last);
                    fail_count++;
                end
            end
        end
    end

    // configuration channel
    always @(posedge clk) begin
        if (cfg_valid && cfg_ready) begin
            if (cfg_index == cmc_pkg::CFG_CAPACITY) cap_reg = int'(cfg_data);
            else if (cfg_index == cmc_pkg::CFG_RENDEZVOUS) rdv_reg = cfg_data[0];
            cfg_valid <= 1'b0;
            cfg_busy  <= 1'b0;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [4:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_busy  <= 1'b1;
        @(posedge clk);
        while (cfg_busy) @(posedge clk);
    endtask

    // wait for every queued item and result, then let the block settle
    task automatic drain_channel();
        while (pending_items.size() != 0 || start || expected_results.size() != 0)
            @(posedge clk);
        repeat (SLOTS + 6) @(posedge clk);
    endtask

    function automatic cmc_pkg::t_item make_item(logic [1:0] act);
        cmc_pkg::t_item it;
        it.action         = act;
        it.payload        = {$urandom(), $urandom()};
        it.payload_is_eof = ($urandom_range(15) == 0);
        it.waiter_id      = 8'($urandom_range(15));
        it.waiter_valid   = ($urandom_range(7) != 0);
        it.holds_demand   = 1'($urandom_range(1));
        return it;
    endfunction

    // random phase weighted towards traffic that fills and drains the channel
    task automatic random_phase(int n_items);
        cmc_pkg::t_item it;
        int    r;
        for (int i = 0; i < n_items; i++) begin
            r = $urandom_range(99);
            if (r < 40) it = make_item(cmc_pkg::ACT_SEND);
            else if (r < 75) it = make_item(cmc_pkg::ACT_RECV);
            else if (r < 90) it = make_item(cmc_pkg::ACT_ANNOUNCE);
            else if (r < 93) it = make_item(cmc_pkg::ACT_CLOSE);
            else begin
                it = make_item(cmc_pkg::ACT_SEND);
                it.waiter_id = 8'($urandom());
            end
            pending_items.push_back(it);
        end
    endtask

    initial begin
        cmc_pkg::t_item it;
        rst_n      = 1'b0;
        start      = 1'b0;
        item_in    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = cmc_pkg::CFG_CAPACITY;
        cfg_data   = '0;
        cfg_busy   = 1'b0;
        chan_closed = 1'b0;
        demand     = 0;
        cap_reg    = 0;
        rdv_reg    = 1'b0;
        fail_count = 0;
        quiet      = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: small capacity, blocking and wake-ups
        write_reg(cmc_pkg::CFG_CAPACITY, 5'd2);
        write_reg(cmc_pkg::CFG_RENDEZVOUS, 5'd0);
        it = '0;
        it.action = cmc_pkg::ACT_RECV; it.waiter_id = 8'hff; it.waiter_valid = 1'b1;
        pending_items.push_back(it);
        pending_items.push_back(it);
        it.action = cmc_pkg::ACT_SEND; it.payload = '1; it.waiter_id = 8'h00;
        pending_items.push_back(it);
        it.payload = '0;
        pending_items.push_back(it);
        it.waiter_id = 8'ha5;
        pending_items.push_back(it);
        it.waiter_valid = 1'b0; it.waiter_id = 8'h5a;
        pending_items.push_back(it);
        it.payload_is_eof = 1'b1;
        pending_items.push_back(it);
        it = '0; it.action = cmc_pkg::ACT_RECV; it.holds_demand = 1'b1;
        pending_items.push_back(it);
        it.action = cmc_pkg::ACT_ANNOUNCE;
        pending_items.push_back(it);
        drain_channel();

        // directed: rendezvous bound and demand
        write_reg(cmc_pkg::CFG_CAPACITY, 5'd0);
        write_reg(cmc_pkg::CFG_RENDEZVOUS, 5'd1);
        it = '0; it.action = cmc_pkg::ACT_SEND; it.waiter_id = 8'd3; it.waiter_valid = 1'b1;
        pending_items.push_back(it);
        it.action = cmc_pkg::ACT_ANNOUNCE;
        pending_items.push_back(it);
        pending_items.push_back(it);
        it.action = cmc_pkg::ACT_SEND; it.payload = 64'h0123456789abcdef;
        pending_items.push_back(it);
        it.action = cmc_pkg::ACT_RECV; it.holds_demand = 1'b1;
        pending_items.push_back(it);
        it.action = cmc_pkg::ACT_CLOSE;
        pending_items.push_back(it);
        it.action = cmc_pkg::ACT_RECV;
        pending_items.push_back(it);
        it.action = cmc_pkg::ACT_SEND;
        pending_items.push_back(it);
        it.payload_is_eof = 1'b1;
        pending_items.push_back(it);
        it.action = cmc_pkg::ACT_CLOSE;
        pending_items.push_back(it);
        it.action = cmc_pkg::ACT_ANNOUNCE;
        pending_items.push_back(it);
        drain_channel();

        // random phases over several settings, with a stretch of no gaps
        write_reg(cmc_pkg::CFG_CAPACITY, 5'd31);
        write_reg(cmc_pkg::CFG_RENDEZVOUS, 5'd0);
        random_phase(50);
        drain_channel();
        write_reg(cmc_pkg::CFG_CAPACITY, 5'd0);
        quiet = 1'b1;
        random_phase(50);
        drain_channel();
        quiet = 1'b0;
        write_reg(cmc_pkg::CFG_CAPACITY, 5'd16);
        random_phase(50);
        drain_channel();
        write_reg(cmc_pkg::CFG_CAPACITY, 5'd0);
        write_reg(cmc_pkg::CFG_RENDEZVOUS, 5'd1);
        random_phase(50);
        drain_channel();

        if (fail_count == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end

    // overall time limit
    initial begin
        #2ms;
        $display("Test completed with failures");
        $finish;
    end
endmodule
